### rtl/scsa_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and reset values for the size-class slot allocator.
package scsa_pkg;

  localparam int SIZE_W     = 16;  // slot size and request size
  localparam int SLOTS_W    = 9;   // per-class slot count register
  localparam int OFF_W      = 16;  // heap byte offsets at the ports
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int ROW_W      = 16;  // occupancy bits per map row
  localparam int ROW_SEL_W  = 4;   // bit select within a row

  localparam int NUM_CLASSES_DEF = 4;
  localparam int TOTAL_SLOTS_DEF = 256;
  localparam int HEAP_BYTES_DEF  = 65536;

  localparam logic [SLOTS_W-1:0] RESET_SLOTS = SLOTS_W'(64);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_SIZE    = 2'd1,
    STATUS_NO_SLOT     = 2'd2,
    STATUS_OUT_OF_HEAP = 2'd3
  } status_t;

  // Reset slot size of class c: 8, 16, 32, ...
  function automatic logic [SIZE_W-1:0] reset_size(input int c);
    logic [SIZE_W+7:0] v;
    v = (SIZE_W+8)'(8) << (c & 7);
    return v[SIZE_W-1:0];
  endfunction

endpackage

### rtl/scsa_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the slot allocator.
interface scsa_req_if;
  import scsa_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, action, request_size, free_offset, input ready);
  modport sink   (input valid, action, request_size, free_offset, output ready);
endinterface

interface scsa_rsp_if;
  import scsa_pkg::*;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [OFF_W-1:0] slot_offset;

  modport source (output valid, status, slot_offset, input ready);
  modport sink   (input valid, status, slot_offset, output ready);
endinterface

### rtl/scsa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module scsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/scsa_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; quotient known to fit SLOTS_W bits.
module scsa_div #(
  parameter int DIVIDEND_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DIVIDEND_W-1:0]       dividend,
  input  logic [scsa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [scsa_pkg::SLOTS_W-1:0] quotient,
  output logic [DIVIDEND_W-1:0]       remainder
);
  import scsa_pkg::*;

  localparam int TW   = (DIVIDEND_W > SIZE_W + SLOTS_W) ? DIVIDEND_W : SIZE_W + SLOTS_W;
  localparam int CNTW = $clog2(SLOTS_W + 1);

  logic [TW-1:0]   rem_r;
  logic [TW-1:0]   dsh;
  logic [TW-1:0]   diff;
  logic            fits;
  logic [CNTW-1:0] cnt;
  logic            busy;

  assign diff      = rem_r - dsh;
  assign fits      = rem_r >= dsh;
  assign remainder = DIVIDEND_W'(rem_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(SLOTS_W);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= TW'(dividend);
      dsh      <= TW'(divisor) << (SLOTS_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem_r <= diff;
      end
      quotient <= {quotient[SLOTS_W-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

endmodule

### rtl/size_class_slot_allocator.sv
`timescale 1ns / 1ps
// Allocate: check, scan of the map rows (16 bits per row, first row of the first fitting
//   class onward), class lookup, offset multiply; free: check, 9-step divider, map read,
//   map write; a bad size or an out-of-heap offset answers straight after the check.
// One request at a time; the first request after reset or a class register write first
//   rebuilds the class layout: multiply and compare per class, divider if cut by heap room.
// Reset (sync, active high) clears control, restores config defaults and clears the
//   per-row valid bits of the occupancy map; there is no clearing pass over the RAM.
module size_class_slot_allocator #(
  parameter int NUM_CLASSES = scsa_pkg::NUM_CLASSES_DEF,
  parameter int TOTAL_SLOTS = scsa_pkg::TOTAL_SLOTS_DEF,
  parameter int HEAP_BYTES  = scsa_pkg::HEAP_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  scsa_req_if.sink                        req,
  scsa_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scsa_pkg::*;

  // Widths: heap byte counts, slot counts, map rows, bit indexes into the map.
  localparam int BW   = $clog2(HEAP_BYTES + 1);
  localparam int SW   = $clog2(TOTAL_SLOTS + 1);
  localparam int DW   = (BW > OFF_W) ? BW : OFF_W;
  localparam int ROWS = (TOTAL_SLOTS + ROW_W - 1) / ROW_W;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW   = RAW + ROW_SEL_W;
  localparam int MA   = (SW > SLOTS_W) ? SW : SLOTS_W;
  localparam int PW   = MA + SIZE_W;
  localparam int CW   = (PW > DW) ? PW : DW;
  localparam int CLW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BIW  = $clog2(NUM_CLASSES + 1);

  localparam logic [CFG_IDX_W:0] NC_X  = (CFG_IDX_W+1)'(NUM_CLASSES);
  localparam logic [CFG_IDX_W:0] NC2_X = (CFG_IDX_W+1)'(2 * NUM_CLASSES);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_L_MUL = 14'b00000000000010,  // effective count and its byte span
    S_L_CMP = 14'b00000000000100,  // span against heap room
    S_L_DIV = 14'b00000000001000,  // count cut to room / size
    S_A_CHK = 14'b00000000010000,
    S_A_SCN = 14'b00000000100000,
    S_A_CLS = 14'b00000001000000,
    S_A_MUL = 14'b00000010000000,
    S_A_OFF = 14'b00000100000000,
    S_F_CHK = 14'b00001000000000,
    S_F_DIV = 14'b00010000000000,
    S_F_RD  = 14'b00100000000000,
    S_F_WR  = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [SIZE_W-1:0]  class_size  [NUM_CLASSES];
  logic [SLOTS_W-1:0] class_slots [NUM_CLASSES];
  logic [CFG_IDX_W:0] cfg_idx_x;
  logic               cfg_hit;

  // Layout, rebuilt when stale: effective counts, slot and byte bases.
  // Entry NUM_CLASSES of the bases is the end of the used map / heap.
  logic [SLOTS_W-1:0] eff   [NUM_CLASSES];
  logic [SW-1:0]      sbase [NUM_CLASSES+1];
  logic [BW-1:0]      bbase [NUM_CLASSES+1];
  logic               dirty;
  logic [CLW-1:0]     lc;
  logic [BIW-1:0]     lc_b, lc1;
  logic               lc_last;

  // Captured request
  logic              act_r;
  logic [SIZE_W-1:0] size_r;
  logic [OFF_W-1:0]  off_r;

  // Shared multiplier
  logic [MA-1:0]      mul_a;
  logic [SIZE_W-1:0]  mul_b;
  logic [PW-1:0]      mul_p;
  logic [PW-1:0]      prod_r;
  logic [SLOTS_W-1:0] n_r;

  // Layout step terms
  logic [SW-1:0]      srem;
  logic [SLOTS_W-1:0] n_cap, n_l;
  logic [BW-1:0]      rem_l;
  logic               over;
  logic               layout_step;

  // Allocate check
  logic              have_last;
  logic [SIZE_W-1:0] last_sz;
  logic [CLW-1:0]    a_first;
  logic              bad_size;
  logic [XW-1:0]     start_c, last_c;

  // Scan
  logic [XW-1:0]        start_x, last_x;
  logic [RAW-1:0]       rd_row, chk_row;
  logic                 chk_pend;
  logic [ROW_W-1:0]     rdq, scan_mask, free_v;
  logic                 hit;
  logic [ROW_SEL_W-1:0] hit_j;
  logic [XW-1:0]        found_bit;
  logic [CLW-1:0]       fb_cls, cls_r;
  logic [SW-1:0]        idx_r;
  logic [SW-1:0]        fb_s;

  // Free
  logic           ooh;
  logic [CLW-1:0] f_cls;
  logic [XW-1:0]  fbit;

  // Map RAM with row valid bits
  logic [ROWS-1:0]  row_valid;
  logic             rv_q;
  logic             ram_we;
  logic [RAW-1:0]   ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  // Divider
  logic               div_start, div_done;
  logic [DW-1:0]      div_dividend;
  logic [SIZE_W-1:0]  div_divisor;
  logic [SLOTS_W-1:0] div_q;
  logic [DW-1:0]      div_r;

  // Result and output register
  status_t          res_status;
  logic [OFF_W-1:0] res_offset;
  logic             out_valid;
  status_t          out_status;
  logic [OFF_W-1:0] out_offset;
  logic             out_load;
  logic             acc;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.slot_offset = out_offset;
  assign out_load  = (state == S_RESP) && (!out_valid || rsp.ready);

  assign cfg_idx_x = {1'b0, cfg_index};
  assign cfg_hit   = cfg_we && (cfg_idx_x < NC2_X);

  assign lc_b    = BIW'(lc);
  assign lc1     = lc_b + BIW'(1);
  assign lc_last = (lc == CLW'(NUM_CLASSES - 1));

  scsa_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  scsa_div #(.DIVIDEND_W(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Layout step: count capped by map room, byte span through the multiplier
  always_comb begin
    srem  = SW'(TOTAL_SLOTS) - sbase[lc_b];
    n_cap = (MA'(class_slots[lc]) < MA'(srem)) ? class_slots[lc] : SLOTS_W'(srem);
    n_l   = (class_size[lc] == '0) ? '0 : n_cap;
    rem_l = BW'(HEAP_BYTES) - bbase[lc_b];
    over  = CW'(prod_r) > CW'(rem_l);
    layout_step = ((state == S_L_CMP) && !over) || ((state == S_L_DIV) && div_done);
  end

  always_comb begin
    if (state == S_A_MUL) begin
      mul_a = MA'(idx_r);
      mul_b = class_size[cls_r];
    end else begin
      mul_a = MA'(n_l);
      mul_b = class_size[lc];
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Allocate check: last used class bounds the size, scan starts at first fit
  always_comb begin
    have_last = 1'b0;
    last_sz   = '0;
    a_first   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (eff[c] != '0) begin
        have_last = 1'b1;
        last_sz   = class_size[c];
      end
    end
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (eff[c] != '0 && class_size[c] >= size_r) begin
        a_first = CLW'(c);
      end
    end
    bad_size = (size_r == '0) || !have_last || (size_r > last_sz);
    start_c  = XW'(sbase[BIW'(a_first)]);
    last_c   = XW'(sbase[NUM_CLASSES] - SW'(1));
  end

  // Scan: free bits of the returning row inside the scan range
  always_comb begin
    rdq = rv_q ? ram_rdata : '0;
    for (int j = 0; j < ROW_W; j++) begin
      scan_mask[j] = ({chk_row, ROW_SEL_W'(j)} >= start_x) &&
                     ({chk_row, ROW_SEL_W'(j)} <= last_x);
    end
    free_v = ~rdq & scan_mask;
    hit    = chk_pend && (free_v != '0);
    hit_j  = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (free_v[j]) begin
        hit_j = ROW_SEL_W'(j);
      end
    end
  end

  // Class lookups: of the found bit, and of the offset to free
  always_comb begin
    fb_s   = SW'(found_bit);
    fb_cls = '0;
    f_cls  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (eff[c] != '0 && fb_s >= sbase[c] && fb_s < sbase[c+1]) begin
        fb_cls = CLW'(c);
      end
      if (eff[c] != '0 && DW'(off_r) >= DW'(bbase[c]) && DW'(off_r) < DW'(bbase[c+1])) begin
        f_cls = CLW'(c);
      end
    end
    ooh = DW'(off_r) >= DW'(bbase[NUM_CLASSES]);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_row;
    ram_wdata = rdq | (ROW_W'(1) << hit_j);
    ram_raddr = rd_row;
    if (state == S_A_SCN && hit) begin
      ram_we = 1'b1;
    end
    if (state == S_F_RD) begin
      ram_raddr = fbit[XW-1:ROW_SEL_W];
    end
    if (state == S_F_WR) begin
      ram_we    = 1'b1;
      ram_waddr = fbit[XW-1:ROW_SEL_W];
      ram_wdata = rdq & ~(ROW_W'(1) << fbit[ROW_SEL_W-1:0]);
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(rem_l);
    div_divisor  = class_size[lc];
    if (state == S_L_CMP && over) begin
      div_start = 1'b1;
    end
    if (state == S_F_CHK) begin
      div_start    = !ooh;
      div_dividend = DW'(off_r) - DW'(bbase[BIW'(f_cls)]);
      div_divisor  = class_size[f_cls];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (dirty) begin
            state_next = S_L_MUL;
          end else begin
            state_next = (req.action == ACT_FREE) ? S_F_CHK : S_A_CHK;
          end
        end
      end
      S_L_MUL: state_next = S_L_CMP;
      S_L_CMP, S_L_DIV: begin
        if (state == S_L_CMP && over) begin
          state_next = S_L_DIV;
        end else if (layout_step) begin
          if (lc_last) begin
            state_next = (act_r == ACT_FREE) ? S_F_CHK : S_A_CHK;
          end else begin
            state_next = S_L_MUL;
          end
        end
      end
      S_A_CHK: state_next = bad_size ? S_RESP : S_A_SCN;
      S_A_SCN: begin
        if (hit) begin
          state_next = S_A_CLS;
        end else if (chk_pend && chk_row == last_x[XW-1:ROW_SEL_W]) begin
          state_next = S_RESP;
        end
      end
      S_A_CLS: state_next = S_A_MUL;
      S_A_MUL: state_next = S_A_OFF;
      S_A_OFF: state_next = S_RESP;
      S_F_CHK: state_next = ooh ? S_RESP : S_F_DIV;
      S_F_DIV: begin
        if (div_done) begin
          state_next = S_F_RD;
        end
      end
      S_F_RD:  state_next = S_F_WR;
      S_F_WR:  state_next = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dirty     <= 1'b1;
      lc        <= '0;
      chk_pend  <= 1'b0;
      out_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        dirty <= 1'b1;
      end else if (layout_step && lc_last) begin
        dirty <= 1'b0;
      end
      if (acc) begin
        lc <= '0;
      end else if (layout_step) begin
        lc <= lc + CLW'(1);
      end
      if (state == S_A_CHK) begin
        chk_pend <= 1'b0;
      end else if (state == S_A_SCN) begin
        chk_pend <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      // a write to a class register empties the map
      if (cfg_hit) begin
        row_valid <= '0;
      end else if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_size[c]  <= reset_size(c);
        class_slots[c] <= RESET_SLOTS;
      end
    end else if (cfg_hit) begin
      if (cfg_idx_x < NC_X) begin
        class_size[CLW'(cfg_index)] <= cfg_data[SIZE_W-1:0];
      end else begin
        class_slots[CLW'(cfg_idx_x - NC_X)] <= cfg_data[SLOTS_W-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rv_q <= row_valid[ram_raddr];
    if (acc) begin
      act_r  <= req.action;
      size_r <= req.request_size;
      off_r  <= req.free_offset;
      if (dirty) begin
        sbase[0] <= '0;
        bbase[0] <= '0;
      end
    end
    if (state == S_L_MUL || state == S_A_MUL) begin
      prod_r <= mul_p;
    end
    if (state == S_L_MUL) begin
      n_r <= n_l;
    end
    if (state == S_L_CMP && !over) begin
      eff[lc]    <= n_r;
      sbase[lc1] <= sbase[lc_b] + SW'(n_r);
      bbase[lc1] <= bbase[lc_b] + BW'(prod_r);
    end
    // cut class ends exactly where room / size slots end
    if (state == S_L_DIV && div_done) begin
      eff[lc]    <= div_q;
      sbase[lc1] <= sbase[lc_b] + SW'(div_q);
      bbase[lc1] <= BW'(HEAP_BYTES) - BW'(div_r);
    end
    case (state)
      S_A_CHK: begin
        start_x    <= start_c;
        last_x     <= last_c;
        rd_row     <= start_c[XW-1:ROW_SEL_W];
        res_status <= STATUS_BAD_SIZE;
        res_offset <= '0;
      end
      S_A_SCN: begin
        rd_row     <= rd_row + RAW'(1);
        chk_row    <= rd_row;
        found_bit  <= {chk_row, hit_j};
        res_status <= STATUS_NO_SLOT;
        res_offset <= '0;
      end
      S_A_CLS: begin
        cls_r <= fb_cls;
        idx_r <= fb_s - sbase[BIW'(fb_cls)];
      end
      S_A_OFF: begin
        res_status <= STATUS_OK;
        res_offset <= OFF_W'(bbase[BIW'(cls_r)] + BW'(prod_r));
      end
      S_F_CHK: begin
        cls_r      <= f_cls;
        res_status <= STATUS_OUT_OF_HEAP;
        res_offset <= '0;
      end
      S_F_DIV: begin
        fbit <= XW'(sbase[BIW'(cls_r)] + SW'(div_q));
      end
      S_F_WR: begin
        res_status <= STATUS_OK;
        res_offset <= '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

`ifndef SYNTHESIS
  // map writes come only from a scan hit or a free
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_A_SCN && hit) || state == S_F_WR))
    else $error("map write outside scan hit or free");

  // a request taken with a stale layout rebuilds it first
  assert property (@(posedge clk) disable iff (rst)
    (acc && dirty) |=> (state == S_L_MUL))
    else $error("stale layout not rebuilt");

  // a write to a class register empties the map
  assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (row_valid == '0))
    else $error("map not cleared by config write");

  // divider results are consumed only where a division is pending
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_L_DIV || state == S_F_DIV))
    else $error("divider done with no division pending");
`endif

endmodule

### bench/scsa_tb_pkg.sv
`timescale 1ns / 1ps
// Config register indexes of the slot allocator, shared by the bench files.
package scsa_tb_pkg;
  import scsa_pkg::*;

  localparam int CFG_SIZE_BASE  = 0;
  localparam int CFG_SLOTS_BASE = CFG_SIZE_BASE + NUM_CLASSES_DEF;
  localparam int CFG_SPARE_BASE = CFG_SLOTS_BASE + NUM_CLASSES_DEF;  // no register here
  localparam int CFG_INDEX_LAST = (1 << CFG_IDX_W) - 1;

endpackage

### bench/scsa_checker.sv
`timescale 1ns / 1ps
// Checker for the slot allocator: mirrors layout and occupancy, compares each response.
module scsa_checker
  import scsa_pkg::*;
  import scsa_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  scsa_req_if                   req,
  scsa_rsp_if                   rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  drained,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int     NCL       = NUM_CLASSES_DEF;
  localparam int     SLOTS     = TOTAL_SLOTS_DEF;
  localparam longint HEAP      = HEAP_BYTES_DEF;
  localparam int     PRINT_CAP = 40;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] slot_offset;
  } reply_t;

  logic [SIZE_W-1:0]  slot_size  [NCL];
  logic [SLOTS_W-1:0] slot_count [NCL];
  logic [SLOTS-1:0]   occupied;
  longint             eff_count  [NCL];
  longint             byte_base  [NCL];
  longint             bit_base   [NCL];
  longint             heap_end;
  reply_t             pending_replies [$];
  int                 fail_count = 0;
  int                 queued = 0;
  int                 reply_no = 0;
  logic               drain_seen = 1'b0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Classes sit back to back; counts get trimmed to the bitmap and heap room left.
  function automatic void build_layout();
    longint bytes, bits, n, room;
    int     c;
    bytes = 0;
    bits  = 0;
    for (c = 0; c < NCL; c++) begin
      byte_base[c] = bytes;
      bit_base[c]  = bits;
      n = slot_count[c];
      if (slot_size[c] == 0) begin
        n = 0;
      end else begin
        room = (HEAP - bytes) / slot_size[c];
        if (n > SLOTS - bits) n = SLOTS - bits;
        if (n > room) n = room;
      end
      eff_count[c] = n;
      bytes += n * slot_size[c];
      bits  += n;
    end
    heap_end = bytes;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0]  idx,
                                      input logic [CFG_DATA_W-1:0] data);
    if (idx < CFG_SLOTS_BASE) begin
      slot_size[idx - CFG_SIZE_BASE] = data;
      occupied = '0;
    end else if (idx < CFG_SPARE_BASE) begin
      slot_count[idx - CFG_SLOTS_BASE] = data[SLOTS_W-1:0];
      occupied = '0;
    end
  endfunction

  function automatic reply_t serve_request(input logic              act,
                                           input logic [SIZE_W-1:0] want,
                                           input logic [OFF_W-1:0]  where);
    reply_t r;
    int     c, last, first;
    longint i, rel;
    logic   found;
    build_layout();
    r.status      = STATUS_OK;
    r.slot_offset = '0;
    if (act == ACT_ALLOC) begin
      last  = -1;
      first = -1;
      found = 1'b0;
      for (c = 0; c < NCL; c++) if (eff_count[c] != 0) last = c;
      if (want == 0 || last < 0 || want > slot_size[last]) begin
        r.status = STATUS_BAD_SIZE;
      end else begin
        for (c = NCL - 1; c >= 0; c--)
          if (eff_count[c] != 0 && slot_size[c] >= want) first = c;
        // upward from the first fit, whatever the sizes of the later classes
        for (c = first; c < NCL && !found; c++)
          for (i = 0; i < eff_count[c] && !found; i++)
            if (!occupied[bit_base[c] + i]) begin
              occupied[bit_base[c] + i] = 1'b1;
              r.slot_offset = OFF_W'(byte_base[c] + i * slot_size[c]);
              found = 1'b1;
            end
        if (!found) r.status = STATUS_NO_SLOT;
      end
    end else if (where >= heap_end) begin
      r.status = STATUS_OUT_OF_HEAP;
    end else begin
      for (c = 0; c < NCL; c++)
        if (eff_count[c] != 0 && where >= byte_base[c] &&
            where < byte_base[c] + eff_count[c] * slot_size[c]) begin
          rel = (where - byte_base[c]) / slot_size[c];
          occupied[bit_base[c] + rel] = 1'b0;
        end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t due;
    int     c;
    if (rst) begin
      for (c = 0; c < NCL; c++) begin
        slot_size[c]  = SIZE_W'(8) << c;
        slot_count[c] = RESET_SLOTS;
      end
      occupied = '0;
      pending_replies.delete();
      drain_seen = 1'b0;
      queued <= 0;
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (req.valid && req.ready)
        pending_replies.push_back(serve_request(req.action, req.request_size,
                                                req.free_offset));
      if (rsp.valid && rsp.ready) begin
        reply_no++;
        if (pending_replies.size() == 0) begin
          report($sformatf("response %0d with no request outstanding", reply_no));
        end else begin
          due = pending_replies.pop_front();
          if (rsp.status !== due.status)
            report($sformatf("response %0d: status %0d, expected %0d", reply_no,
                             rsp.status, due.status));
          if (rsp.slot_offset !== due.slot_offset)
            report($sformatf("response %0d: slot_offset 0x%04h, expected 0x%04h",
                             reply_no, rsp.slot_offset, due.slot_offset));
        end
      end
      if (drained && !drain_seen) begin
        drain_seen = 1'b1;
        if (pending_replies.size() != 0)
          report($sformatf("%0d requests never answered", pending_replies.size()));
      end
      queued <= pending_replies.size();
    end
  end

endmodule

### bench/size_class_slot_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench top for the size-class slot allocator: stimulus, handshake idling and verdict.
module size_class_slot_allocator_tb;
  import scsa_pkg::*;
  import scsa_tb_pkg::*;

  localparam int NCL             = NUM_CLASSES_DEF;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 54;   // ~650 random requests in total
  localparam int GAP_MAX         = 16;
  // Sized against the worst allocate plus the layout rebuild after a config write.
  localparam int SETTLE_CYCLES   = 64;
  // ~700 requests with their gaps, block time and stalls take ~0.6 ms; several times that.
  localparam int TIMEOUT_NS      = 5_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  drained;
  int                    mismatches;
  int                    outstanding;

  // Idle limits per phase; zero gives a stretch with no idling on that side.
  int                    req_gap_max   = GAP_MAX;
  int                    rsp_stall_max = GAP_MAX;

  // What was last written per register; only used to aim the random requests.
  logic [SIZE_W-1:0]     size_reg  [NCL];
  logic [SLOTS_W-1:0]    count_reg [NCL];
  // Values the next config load writes (counts carry the full port width).
  logic [CFG_DATA_W-1:0] staged_size  [NCL];
  logic [CFG_DATA_W-1:0] staged_count [NCL];

  scsa_req_if req_ch ();
  scsa_rsp_if rsp_ch ();

  size_class_slot_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scsa_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .drained     (drained),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #(TIMEOUT_NS);
    $display("size_class_slot_allocator regression: fail");
    $finish;
  end

  // Response side: random stall before each response, ready held until it is taken.
  // Ready is only dropped when a stall is drawn, so it never toggles within one step.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (rsp_stall_max == 0) ? 0 : $urandom_range(rsp_stall_max);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // One request. Valid stays up after the accept so a back-to-back request needs no
  // second assignment in that step; whoever stops sending drops it.
  task automatic send(input logic act, input logic [SIZE_W-1:0] want,
                      input logic [OFF_W-1:0] where);
    int gap;
    gap = (req_gap_max == 0) ? 0 : $urandom_range(req_gap_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.request_size <= want;
    req_ch.free_offset  <= where;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Called in the step of the last accept: stop sending, let every response come back,
  // then give the block time to settle before anything touches its config.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    @(posedge clk);
    if (idx < CFG_SLOTS_BASE)
      size_reg[idx - CFG_SIZE_BASE] = data;
    else if (idx < CFG_SPARE_BASE)
      count_reg[idx - CFG_SLOTS_BASE] = data[SLOTS_W-1:0];
  endtask

  // Writes the staged registers picked by the mask, back to back, once the block is
  // idle. A spare write goes to an index with no register behind it.
  task automatic load_config(input logic [2*NCL-1:0] which, input logic spare);
    int c;
    wait_idle();
    for (c = 0; c < NCL; c++)
      if (which[c]) write_reg(CFG_SIZE_BASE + c, staged_size[c]);
    for (c = 0; c < NCL; c++)
      if (which[NCL + c]) write_reg(CFG_SLOTS_BASE + c, staged_count[c]);
    if (spare) write_reg($urandom_range(CFG_INDEX_LAST, CFG_SPARE_BASE), $urandom);
    cfg_we <= 1'b0;
  endtask

  // Config shapes that rotate over the phases.
  task automatic pick_config(input int phase, output logic [2*NCL-1:0] which);
    int c;
    which = '1;
    case (phase % 4)
      0: begin
        // small ascending classes, few slots: the map fills up quickly
        staged_size[0] = $urandom_range(8, 1);
        for (c = 1; c < NCL; c++) staged_size[c] = staged_size[c-1] + $urandom_range(8);
        for (c = 0; c < NCL; c++) staged_count[c] = $urandom_range(6);
      end
      1: begin
        // mid sizes, wide counts, and only part of the registers rewritten
        staged_size[0] = $urandom_range(64, 1);
        for (c = 1; c < NCL; c++)
          staged_size[c] = staged_size[c-1] + $urandom_range(200, 1);
        for (c = 0; c < NCL; c++) staged_count[c] = $urandom_range(256);
        which = $urandom;
      end
      2: begin
        // anything the port carries: unordered sizes, heap room cuts, counts above 256
        for (c = 0; c < NCL; c++) begin
          staged_size[c]  = $urandom;
          staged_count[c] = $urandom;
          if ($urandom_range(3) == 0) staged_size[c] = $urandom_range(300);
        end
      end
      default: begin
        case ((phase / 4) % 3)
          0: begin
            // largest slots: one slot fits, the rest of the heap has no room
            for (c = 0; c < NCL; c++) begin
              staged_size[c]  = '1;
              staged_count[c] = TOTAL_SLOTS_DEF;
            end
          end
          1: begin
            // one-byte slots, class 0 takes the whole bitmap
            staged_size[0]  = 1;
            staged_count[0] = TOTAL_SLOTS_DEF;
            for (c = 1; c < NCL; c++) begin
              staged_size[c]  = $urandom_range(512, 2);
              staged_count[c] = $urandom_range(256, 1);
            end
          end
          default: begin
            // class 0 covers every heap byte and every bitmap bit
            for (c = 0; c < NCL; c++) begin
              staged_size[c]  = HEAP_BYTES_DEF / TOTAL_SLOTS_DEF;
              staged_count[c] = TOTAL_SLOTS_DEF;
            end
          end
        endcase
      end
    endcase
  endtask

  // Mostly allocates that fit some class and frees inside the heap, plus zero sizes,
  // one-past-a-class sizes, offsets around the heap end and raw 16-bit values.
  task automatic random_request();
    int                unsigned kind, c;
    int                span;
    logic [SIZE_W-1:0] want;
    logic [OFF_W-1:0]  where;
    span = 0;
    for (c = 0; c < NCL; c++) span += int'(size_reg[c]) * int'(count_reg[c]);
    if (span > HEAP_BYTES_DEF) span = HEAP_BYTES_DEF;
    if (span == 0) span = 1;
    c    = $urandom_range(NCL - 1);
    kind = $urandom_range(9);
    if ($urandom_range(99) < 55) begin
      if (kind < 7)       want = $urandom_range((size_reg[c] == 0) ? 1 : size_reg[c], 1);
      else if (kind == 7) want = '0;
      else if (kind == 8) want = size_reg[c] + 1'b1;
      else                want = $urandom;
      send(ACT_ALLOC, want, $urandom);
    end else begin
      if (kind < 7)       where = $urandom_range(span - 1);
      else if (kind == 7) where = OFF_W'(span - 1 + $urandom_range(2));
      else                where = $urandom;
      send(ACT_FREE, $urandom, where);
    end
  endtask

  initial begin
    int               phase, n, c;
    logic [2*NCL-1:0] which;

    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_ALLOC;
    req_ch.request_size <= '0;
    req_ch.free_offset  <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    drained             <= 1'b0;
    for (c = 0; c < NCL; c++) begin
      size_reg[c]  = SIZE_W'(8) << c;
      count_reg[c] = RESET_SLOTS;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: 64 slots each of 8/16/32/64 bytes, heap ends at byte 7680.
    send(ACT_ALLOC, 16'd0, 16'd0);         // zero size
    send(ACT_ALLOC, 16'hFFFF, 16'hFFFF);   // largest request
    send(ACT_ALLOC, 16'd65, 16'd0);        // one past the largest class
    send(ACT_ALLOC, 16'd1, 16'd0);         // smallest request, first slot
    send(ACT_ALLOC, 16'd8, 16'd0);         // exact fit of class 0
    send(ACT_ALLOC, 16'd9, 16'd0);         // spills into class 1
    send(ACT_ALLOC, 16'd64, 16'd0);        // only the last class fits
    send(ACT_FREE, 16'd0, 16'd7679);       // last heap byte, slot already free
    send(ACT_FREE, 16'd0, 16'd7680);       // first byte past the heap
    send(ACT_FREE, 16'hFFFF, 16'hFFFF);    // top offset
    send(ACT_FREE, 16'd0, 16'd4);          // inside the first slot frees it
    send(ACT_ALLOC, 16'd3, 16'd0);         // reuses that slot
    send(ACT_FREE, 16'd0, 16'd0);

    // Tiny layout: class 0 one 4-byte slot, class 1 one 2-byte slot (smaller than
    // class 0), class 2 has no size, class 3 no slots. Heap is bytes 0..5.
    staged_size  = '{16'd4, 16'd2, 16'd0, 16'd16};
    staged_count = '{16'd1, 16'd1, 16'd5, 16'd0};
    load_config('1, 1'b0);
    send(ACT_ALLOC, 16'd3, 16'd0);         // fits class 0 but exceeds the last used class
    send(ACT_ALLOC, 16'd2, 16'd0);         // takes class 0
    load_config('0, 1'b1);                 // write to a spare index keeps the map
    send(ACT_ALLOC, 16'd1, 16'd0);         // class 0 full, moves up to class 1
    send(ACT_ALLOC, 16'd2, 16'd0);         // nothing free
    send(ACT_FREE, 16'd0, 16'd5);          // middle of the class 1 slot
    send(ACT_FREE, 16'd0, 16'd6);          // just past the heap
    send(ACT_ALLOC, 16'd2, 16'd0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_config(phase, which);
      load_config(which, $urandom_range(1));
      req_gap_max   = (phase % 3 == 1) ? 0 : GAP_MAX;
      rsp_stall_max = (phase % 4 == 2) ? 0 : GAP_MAX;
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_request();
    end

    wait_idle();
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("size_class_slot_allocator regression: pass");
    end else begin
      $display("size_class_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule
